@@ hw/rtl/fcc_pkg.sv @@
`default_nettype none

package fcc_pkg;

  // Field widths fixed by the item format.
  localparam int MAP_W     = 6;
  localparam int FRAC_W    = 16;
  localparam int WD_W      = 24;
  localparam int ROW_W     = 9;
  localparam int COL_W     = 10;
  localparam int POS_W     = 22;
  localparam int TEX_W     = 6;
  localparam int CFG_IDX_W = 1;

  // Base point is at most 64.0 in Q16, and |base - player| fits the same width.
  localparam int BASE_W = MAP_W + 1 + FRAC_W;
  localparam int MAG_W  = BASE_W;
  localparam int DIFF_W = BASE_W + 1;

  // 2y - rows stays below 2^10 for any nine-bit row.
  localparam int DEN1_W = ROW_W + 1;

  // Quotient bits resolved per divider stage.
  localparam int DIV_STEP = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_PLAYER_X = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PLAYER_Y = 1'b1;

  typedef struct packed {
    logic [BASE_W-1:0] bx;
    logic [BASE_W-1:0] by;
    logic [WD_W-1:0]   wd;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              rej;
  } row_side_t;

  typedef struct packed {
    logic              neg;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              rej;
  } tail_t;

endpackage

`default_nettype wire

@@ hw/rtl/fcc_div.sv @@
`default_nettype none

module fcc_div import fcc_pkg::*; #(
  parameter int NUM_W  = 25,
  parameter int DEN_W  = 10,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  in_num,
  input  logic [DEN_W-1:0]  in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [NUM_W-1:0]  out_quot,
  output logic [SIDE_W-1:0] out_side
);

  localparam int NST = (NUM_W + DIV_STEP - 1) / DIV_STEP;

  // The numerator shifts out at the top while quotient bits shift in at the bottom.
  logic              v_a    [0:NST];
  logic [DEN_W-1:0]  rem_a  [0:NST];
  logic [NUM_W-1:0]  nq_a   [0:NST];
  logic [DEN_W-1:0]  den_a  [0:NST];
  logic [SIDE_W-1:0] side_a [0:NST];

  assign v_a[0]    = in_valid;
  assign rem_a[0]  = '0;
  assign nq_a[0]   = in_num;
  assign den_a[0]  = in_den;
  assign side_a[0] = in_side;

  for (genvar s = 0; s < NST; s++) begin : g_stage
    localparam int FIRST = s * DIV_STEP;
    localparam int CNT   = (NUM_W - FIRST < DIV_STEP) ? (NUM_W - FIRST) : DIV_STEP;

    logic              v_r;
    logic [DEN_W-1:0]  rem_r;
    logic [NUM_W-1:0]  nq_r;
    logic [DEN_W-1:0]  den_r;
    logic [SIDE_W-1:0] side_r;
    logic [DEN_W-1:0]  rem_nxt;
    logic [NUM_W-1:0]  nq_nxt;

    always_comb begin : restore
      logic [DEN_W:0] trial;
      rem_nxt = rem_a[s];
      nq_nxt  = nq_a[s];
      trial   = '0;
      for (int k = 0; k < CNT; k++) begin
        trial = {rem_nxt, nq_nxt[NUM_W-1]};
        if (trial >= {1'b0, den_a[s]}) begin
          rem_nxt = DEN_W'(trial - {1'b0, den_a[s]});
          nq_nxt  = {nq_nxt[NUM_W-2:0], 1'b1};
        end else begin
          rem_nxt = trial[DEN_W-1:0];
          nq_nxt  = {nq_nxt[NUM_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (adv) begin
        v_r <= v_a[s];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r  <= rem_nxt;
        nq_r   <= nq_nxt;
        den_r  <= den_a[s];
        side_r <= side_a[s];
      end
    end

    assign v_a[s+1]    = v_r;
    assign rem_a[s+1]  = rem_r;
    assign nq_a[s+1]   = nq_r;
    assign den_a[s+1]  = den_r;
    assign side_a[s+1] = side_r;
  end

  assign out_valid = v_a[NST];
  assign out_quot  = nq_a[NST];
  assign out_side  = side_a[NST];

endmodule

`default_nettype wire

@@ hw/rtl/fcc_axis.sv @@
`default_nettype none

module fcc_axis import fcc_pkg::*; #(
  parameter int TSIZE = 64,
  parameter int Q_W   = 48
) (
  input  logic             clk,
  input  logic             adv,
  input  logic [Q_W-1:0]   in_off,
  input  logic [POS_W-1:0] in_pos,
  input  logic             in_neg,
  output logic [TEX_W-1:0] out_texel,
  output logic             out_ok
);

  localparam int TW = $clog2(TSIZE);

  logic [Q_W:0]          sum;
  logic [Q_W:0]          sub;
  logic                  gt;
  logic [FRAC_W-1:0]     lo_back;
  logic [FRAC_W-1:0]     lo_nxt;
  logic                  isneg_nxt;
  logic                  small_nxt;
  logic [FRAC_W-1:0]     lo_r;
  logic                  isneg_r;
  logic                  small_r;
  logic [FRAC_W+TW-1:0]  tprod;
  logic [TW-1:0]         tq;
  logic [TW+TEX_W-1:0]   tq_ext;

  // Only the fraction of the blended point picks the texel, since the integer
  // part contributes whole multiples of the texture size.
  always_comb begin
    sum       = {1'b0, in_off} + (Q_W+1)'(in_pos);
    sub       = {1'b0, in_off} - (Q_W+1)'(in_pos);
    gt        = !sub[Q_W] && (sub[Q_W-1:0] != '0);
    lo_back   = ~sub[FRAC_W-1:0] + FRAC_W'(1);
    isneg_nxt = in_neg && gt;
    small_nxt = (sub[Q_W-1:FRAC_W] == '0);
    priority if (!in_neg) begin
      lo_nxt = sum[FRAC_W-1:0];
    end else if (gt) begin
      lo_nxt = sub[FRAC_W-1:0];
    end else begin
      lo_nxt = lo_back;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lo_r    <= lo_nxt;
      isneg_r <= isneg_nxt;
      small_r <= small_nxt;
    end
  end

  // A point just left of zero still maps to texel zero when it is less than
  // one texel away.
  always_comb begin
    tprod     = (FRAC_W+TW)'(lo_r) * (FRAC_W+TW)'(TSIZE);
    tq        = tprod[FRAC_W +: TW];
    tq_ext    = {{TEX_W{1'b0}}, tq};
    out_texel = tq_ext[TEX_W-1:0];
    out_ok    = !isneg_r || (small_r && (tq == '0));
  end

endmodule

`default_nettype wire

@@ hw/rtl/floor_ceiling_texel_caster.sv @@
`default_nettype none

// Floor and ceiling caster: each item is one screen row under a wall slice and
// yields one result with the floor row, the mirrored ceiling row, the column
// and the texture coordinates of the floor point, or texel_valid low with zero
// rows and texels. The pipeline takes one item per clock while the output
// is not stalled. Most of its registers sit in the restoring dividers (row
// distance, then the x and y blend offsets over wall distance), each
// resolving two quotient bits per stage. A stalled output holds the whole
// pipeline only once the stage in front of the output register is occupied.
// player_x and player_y must be written only with no item in flight; the
// block does not enforce this.

module floor_ceiling_texel_caster import fcc_pkg::*; #(
  parameter int SCREEN_ROWS  = 480,
  parameter int TEXTURE_COLS = 64,
  parameter int TEXTURE_ROWS = 64,
  parameter int MAP_CELLS    = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [POS_W-1:0]     cfg_data,

  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [MAP_W-1:0]     in_map_x,
  input  logic [MAP_W-1:0]     in_map_y,
  input  logic signed [1:0]    in_ray_x_sign,
  input  logic                 in_ray_y_positive,
  input  logic [FRAC_W-1:0]    in_wall_hit_fraction,
  input  logic                 in_hit_side,
  input  logic [WD_W-1:0]      in_wall_distance,
  input  logic [ROW_W-1:0]     in_screen_row,
  input  logic [COL_W-1:0]     in_screen_column,

  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [ROW_W-1:0]     out_floor_row,
  output logic [ROW_W-1:0]     out_ceiling_row,
  output logic [COL_W-1:0]     out_column_out,
  output logic [TEX_W-1:0]     out_texel_x,
  output logic [TEX_W-1:0]     out_texel_y,
  output logic                 out_texel_valid
);

  localparam int NUM1_W = $clog2(SCREEN_ROWS + 1) + FRAC_W;
  localparam int PROD_W = NUM1_W + MAG_W;
  localparam logic [NUM1_W-1:0] ROW_NUM = NUM1_W'(SCREEN_ROWS * 65536);

  logic adv;
  logic v_last;

  // Configuration registers.
  logic [POS_W-1:0] player_x_r;
  logic [POS_W-1:0] player_y_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      player_x_r <= '0;
      player_y_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PLAYER_X: player_x_r <= cfg_data;
        CFG_PLAYER_Y: player_y_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage 1: wall base point, row checks and row divisor.
  logic [BASE_W-1:0] cell_x;
  logic [BASE_W-1:0] cell_y;
  logic [BASE_W-1:0] frac_ext;
  logic [BASE_W-1:0] one_ext;
  logic [31:0]       den_full;
  row_side_t         s1_side_nxt;
  logic [DEN1_W-1:0] s1_den_nxt;

  logic              s1_v_r;
  row_side_t         s1_side_r;
  logic [DEN1_W-1:0] s1_den_r;

  always_comb begin
    cell_x   = {1'b0, in_map_x, {FRAC_W{1'b0}}};
    cell_y   = {1'b0, in_map_y, {FRAC_W{1'b0}}};
    frac_ext = BASE_W'(in_wall_hit_fraction);
    one_ext  = BASE_W'(1) << FRAC_W;
    den_full = 32'(2 * int'(in_screen_row) - SCREEN_ROWS);

    priority if (!in_hit_side && (in_ray_x_sign == 2'sd1)) begin
      s1_side_nxt.bx = cell_x;
      s1_side_nxt.by = cell_y + frac_ext;
    end else if (!in_hit_side && in_ray_x_sign[1]) begin
      s1_side_nxt.bx = cell_x + one_ext;
      s1_side_nxt.by = cell_y + frac_ext;
    end else if (in_hit_side && in_ray_y_positive) begin
      s1_side_nxt.bx = cell_x + frac_ext;
      s1_side_nxt.by = cell_y;
    end else begin
      s1_side_nxt.bx = cell_x + frac_ext;
      s1_side_nxt.by = cell_y + one_ext;
    end

    // A zero wall distance counts as one LSB.
    s1_side_nxt.wd  = (in_wall_distance == '0) ? WD_W'(1) : in_wall_distance;
    s1_side_nxt.row = in_screen_row;
    s1_side_nxt.col = in_screen_column;
    s1_side_nxt.rej = (2 * int'(in_screen_row) <= SCREEN_ROWS)
                   || (int'(in_screen_row) >= SCREEN_ROWS)
                   || (int'(in_map_x) >= MAP_CELLS)
                   || (int'(in_map_y) >= MAP_CELLS);
    s1_den_nxt = den_full[DEN1_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_side_r <= s1_side_nxt;
      s1_den_r  <= s1_den_nxt;
    end
  end

  // Row distance rows * 2^16 / (2y - rows).
  logic              d1_v;
  logic [NUM1_W-1:0] d1_dist;
  row_side_t         d1_side;

  fcc_div #(
    .NUM_W  (NUM1_W),
    .DEN_W  (DEN1_W),
    .SIDE_W ($bits(row_side_t))
  ) u_row_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (s1_v_r),
    .in_num    (ROW_NUM),
    .in_den    (s1_den_r),
    .in_side   (s1_side_r),
    .out_valid (d1_v),
    .out_quot  (d1_dist),
    .out_side  (d1_side)
  );

  // Stage 2: signed offset of the base point from the player.
  logic [DIFF_W-1:0] dx;
  logic [DIFF_W-1:0] dy;
  logic [DIFF_W-1:0] dx_abs;
  logic [DIFF_W-1:0] dy_abs;

  logic              s2_v_r;
  logic [NUM1_W-1:0] s2_dist_r;
  logic [MAG_W-1:0]  s2_magx_r;
  logic [MAG_W-1:0]  s2_magy_r;
  logic              s2_negx_r;
  logic              s2_negy_r;
  logic [WD_W-1:0]   s2_wd_r;
  logic [ROW_W-1:0]  s2_row_r;
  logic [COL_W-1:0]  s2_col_r;
  logic              s2_rej_r;

  always_comb begin
    dx     = {1'b0, d1_side.bx} - DIFF_W'(player_x_r);
    dy     = {1'b0, d1_side.by} - DIFF_W'(player_y_r);
    dx_abs = dx[DIFF_W-1] ? (~dx + DIFF_W'(1)) : dx;
    dy_abs = dy[DIFF_W-1] ? (~dy + DIFF_W'(1)) : dy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s2_v_r <= d1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_dist_r <= d1_dist;
      s2_magx_r <= dx_abs[MAG_W-1:0];
      s2_magy_r <= dy_abs[MAG_W-1:0];
      s2_negx_r <= dx[DIFF_W-1];
      s2_negy_r <= dy[DIFF_W-1];
      s2_wd_r   <= d1_side.wd;
      s2_row_r  <= d1_side.row;
      s2_col_r  <= d1_side.col;
      s2_rej_r  <= d1_side.rej;
    end
  end

  // Stage 3: distance times offset magnitude, one multiplier per axis.
  logic              s3_v_r;
  logic [PROD_W-1:0] s3_prodx_r;
  logic [PROD_W-1:0] s3_prody_r;
  logic [WD_W-1:0]   s3_wd_r;
  tail_t             s3_tail_r;
  logic              s3_negy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (adv) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_prodx_r    <= PROD_W'(s2_dist_r) * PROD_W'(s2_magx_r);
      s3_prody_r    <= PROD_W'(s2_dist_r) * PROD_W'(s2_magy_r);
      s3_wd_r       <= s2_wd_r;
      s3_tail_r.neg <= s2_negx_r;
      s3_tail_r.row <= s2_row_r;
      s3_tail_r.col <= s2_col_r;
      s3_tail_r.rej <= s2_rej_r;
      s3_negy_r     <= s2_negy_r;
    end
  end

  // Blend offsets over the wall distance.
  logic              d2_v;
  logic [PROD_W-1:0] d2_offx;
  tail_t             d2_tail;
  logic              d2y_v;
  logic [PROD_W-1:0] d2_offy;
  logic              d2_negy;

  fcc_div #(
    .NUM_W  (PROD_W),
    .DEN_W  (WD_W),
    .SIDE_W ($bits(tail_t))
  ) u_x_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (s3_v_r),
    .in_num    (s3_prodx_r),
    .in_den    (s3_wd_r),
    .in_side   (s3_tail_r),
    .out_valid (d2_v),
    .out_quot  (d2_offx),
    .out_side  (d2_tail)
  );

  fcc_div #(
    .NUM_W  (PROD_W),
    .DEN_W  (WD_W),
    .SIDE_W (1)
  ) u_y_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (s3_v_r),
    .in_num    (s3_prody_r),
    .in_den    (s3_wd_r),
    .in_side   (s3_negy_r),
    .out_valid (d2y_v),
    .out_quot  (d2_offy),
    .out_side  (d2_negy)
  );

  // Stage 4: blended point and texel lookup per axis.
  logic [TEX_W-1:0] tex_x;
  logic [TEX_W-1:0] tex_y;
  logic             ok_x;
  logic             ok_y;

  fcc_axis #(
    .TSIZE (TEXTURE_COLS),
    .Q_W   (PROD_W)
  ) u_axis_x (
    .clk       (clk),
    .adv       (adv),
    .in_off    (d2_offx),
    .in_pos    (player_x_r),
    .in_neg    (d2_tail.neg),
    .out_texel (tex_x),
    .out_ok    (ok_x)
  );

  fcc_axis #(
    .TSIZE (TEXTURE_ROWS),
    .Q_W   (PROD_W)
  ) u_axis_y (
    .clk       (clk),
    .adv       (adv),
    .in_off    (d2_offy),
    .in_pos    (player_y_r),
    .in_neg    (d2_negy),
    .out_texel (tex_y),
    .out_ok    (ok_y)
  );

  logic             s4_v_r;
  logic [ROW_W-1:0] s4_row_r;
  logic [COL_W-1:0] s4_col_r;
  logic             s4_rej_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (adv) begin
      s4_v_r <= d2_v && d2y_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_row_r <= d2_tail.row;
      s4_col_r <= d2_tail.col;
      s4_rej_r <= d2_tail.rej;
    end
  end

  // Output register. The pipeline keeps moving while the last stage is empty,
  // even with a result still waiting here.
  logic             ok;
  logic [31:0]      ceil_full;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic [ROW_W-1:0] out_floor_r;
  logic [ROW_W-1:0] out_ceiling_r;
  logic [COL_W-1:0] out_col_r;
  logic [TEX_W-1:0] out_tx_r;
  logic [TEX_W-1:0] out_ty_r;
  logic             out_tv_r;

  assign v_last   = s4_v_r;
  assign adv      = !v_last || !out_valid_r || out_ready;
  assign in_ready = adv;

  always_comb begin
    ok        = !s4_rej_r && ok_x && ok_y;
    ceil_full = 32'(SCREEN_ROWS - int'(s4_row_r));
    priority if (v_last && adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (v_last && adv) begin
      out_floor_r   <= ok ? s4_row_r : '0;
      out_ceiling_r <= ok ? ceil_full[ROW_W-1:0] : '0;
      out_col_r     <= s4_col_r;
      out_tx_r      <= ok ? tex_x : '0;
      out_ty_r      <= ok ? tex_y : '0;
      out_tv_r      <= ok;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_floor_row   = out_floor_r;
  assign out_ceiling_row = out_ceiling_r;
  assign out_column_out  = out_col_r;
  assign out_texel_x     = out_tx_r;
  assign out_texel_y     = out_ty_r;
  assign out_texel_valid = out_tv_r;

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (v_last && out_valid_r && !out_ready) |-> !in_ready)
    else $error("input taken while the pipeline is blocked");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(v_last))
    else $error("result appeared without an item in the last stage");

  a_mirror: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_texel_valid) |->
      (int'(out_ceiling_row) + int'(out_floor_row) == SCREEN_ROWS))
    else $error("ceiling row is not the mirror of the floor row");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_texel_valid) |->
      (out_floor_row == '0 && out_ceiling_row == '0 &&
       out_texel_x == '0 && out_texel_y == '0))
    else $error("invalid item carries nonzero rows or texels");

endmodule

`default_nettype wire
